### hw/rtl/sdv_pkg.sv
`timescale 1ns / 1ps

package sdv_pkg;

  localparam int ANGLE_W   = 11;
  localparam int ECHO_W    = 14;
  localparam int TIME_W    = 32;
  localparam int THRESH_W  = 8;
  localparam int MS_W      = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W    = 19;

  localparam logic [ECHO_W-1:0] MIN_ECHO_US = ECHO_W'(100);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_CM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_MS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED       = 3'd6;

  localparam logic [ANGLE_W-1:0]  RST_ANGLE_LO     = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0]  RST_ANGLE_HI     = ANGLE_W'(1800);
  localparam logic [ANGLE_W-1:0]  RST_ANGLE_STRIDE = ANGLE_W'(20);
  localparam logic [THRESH_W-1:0] RST_THRESHOLD_CM = THRESH_W'(50);
  localparam logic [MS_W-1:0]     RST_VERIFY_MS    = MS_W'(2000);
  localparam logic [MS_W-1:0]     RST_COOLDOWN_MS  = MS_W'(3000);
  localparam logic [ANGLE_W-1:0]  RST_HELD_ANGLE   = ANGLE_W'(900);

  localparam logic [MODE_W-1:0] MODE_CODE_SWEEP  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_VERIFY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_COOL   = 2'd2;

  typedef enum logic [2:0] {
    MODE_SWEEP  = 3'b001,
    MODE_VERIFY = 3'b010,
    MODE_COOL   = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle_lo;
    logic [ANGLE_W-1:0]  angle_hi;
    logic [ANGLE_W-1:0]  angle_stride;
    logic [THRESH_W-1:0] threshold_cm;
    logic [MS_W-1:0]     verify_ms;
    logic [MS_W-1:0]     cooldown_ms;
    logic                paused;
  } cfg_t;

  typedef struct packed {
    scan_mode_t         scan_mode;
    logic               going_up;
    logic [ANGLE_W-1:0] scan_angle;
    logic [TIME_W-1:0]  mode_start_ms;
    logic [ANGLE_W-1:0] held_angle;
  } scan_state_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] servo_angle;
    logic [MODE_W-1:0]  mode;
    logic               fire;
    logic [ANGLE_W-1:0] target_angle;
    logic               end_dwell;
  } result_t;

  function automatic logic [MODE_W-1:0] mode_code(input scan_mode_t m);
    logic [MODE_W-1:0] code;
    case (m)
      MODE_VERIFY: code = MODE_CODE_VERIFY;
      MODE_COOL:   code = MODE_CODE_COOL;
      default:     code = MODE_CODE_SWEEP;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/sdv_ifs.sv
`timescale 1ns / 1ps

interface sdv_step_if
  import sdv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_us;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output echo_us, output now_ms, input ready);
  modport sink (input valid, input echo_us, input now_ms, output ready);
endinterface

interface sdv_result_if
  import sdv_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] servo_angle;
  logic [MODE_W-1:0]  mode;
  logic               fire;
  logic [ANGLE_W-1:0] target_angle;
  logic               end_dwell;

  modport source (output valid, output servo_angle, output mode, output fire,
                  output target_angle, output end_dwell, input ready);
  modport sink (input valid, input servo_angle, input mode, input fire,
                input target_angle, input end_dwell, output ready);
endinterface

### hw/rtl/sdv_cfg.sv
`timescale 1ns / 1ps

module sdv_cfg
  import sdv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_lo     <= RST_ANGLE_LO;
      cfg.angle_hi     <= RST_ANGLE_HI;
      cfg.angle_stride <= RST_ANGLE_STRIDE;
      cfg.threshold_cm <= RST_THRESHOLD_CM;
      cfg.verify_ms    <= RST_VERIFY_MS;
      cfg.cooldown_ms  <= RST_COOLDOWN_MS;
      cfg.paused       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_LO:     cfg.angle_lo     <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_HI:     cfg.angle_hi     <= cfg_data[ANGLE_W-1:0];
        CFG_ANGLE_STRIDE: cfg.angle_stride <= cfg_data[ANGLE_W-1:0];
        CFG_THRESHOLD_CM: cfg.threshold_cm <= cfg_data[THRESH_W-1:0];
        CFG_VERIFY_MS:    cfg.verify_ms    <= cfg_data[MS_W-1:0];
        CFG_COOLDOWN_MS:  cfg.cooldown_ms  <= cfg_data[MS_W-1:0];
        CFG_PAUSED:       cfg.paused       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/sdv_step.sv
`timescale 1ns / 1ps

module sdv_step
  import sdv_pkg::*;
(
  input  cfg_t              cfg,
  input  scan_state_t       state,
  input  logic [ECHO_W-1:0] echo_us,
  input  logic [TIME_W-1:0] now_ms,
  output scan_state_t       state_next,
  output result_t           result
);

  logic [PROD_W-1:0]  echo_x17;
  logic [PROD_W-1:0]  thresh_x1000;
  logic               hit;
  logic [TIME_W-1:0]  verify_elapsed;
  logic [TIME_W-1:0]  cool_start;
  logic [TIME_W-1:0]  cool_elapsed;
  logic [ANGLE_W:0]   up_angle;
  logic [ANGLE_W:0]   down_angle;
  logic               fire;
  logic               dwell;

  always_comb begin
    echo_x17 = PROD_W'({echo_us, 4'b0000}) + PROD_W'(echo_us);
    thresh_x1000 = PROD_W'(cfg.threshold_cm) * PROD_W'(1000);
    hit = (echo_us > MIN_ECHO_US) && (echo_x17 <= thresh_x1000);
    verify_elapsed = now_ms - state.mode_start_ms;
    cool_start = hit ? now_ms : state.mode_start_ms;
    cool_elapsed = now_ms - cool_start;
    up_angle = {1'b0, state.scan_angle} + {1'b0, cfg.angle_stride};
    down_angle = {1'b0, state.scan_angle} - {1'b0, cfg.angle_stride};
  end

  always_comb begin
    state_next = state;
    fire = 1'b0;
    dwell = 1'b0;
    case (state.scan_mode)
      MODE_VERIFY: begin
        if (hit) begin
          if (verify_elapsed >= TIME_W'(cfg.verify_ms)) begin
            fire = 1'b1;
            state_next.scan_mode = MODE_COOL;
            state_next.mode_start_ms = now_ms;
          end
        end else begin
          state_next.scan_mode = MODE_SWEEP;
        end
      end
      MODE_COOL: begin
        state_next.mode_start_ms = cool_start;
        if (cool_elapsed >= TIME_W'(cfg.cooldown_ms)) begin
          state_next.scan_mode = MODE_SWEEP;
        end
      end
      default: begin
        state_next.scan_mode = MODE_SWEEP;
        if (hit) begin
          state_next.scan_mode = MODE_VERIFY;
          state_next.mode_start_ms = now_ms;
          state_next.held_angle = state.scan_angle;
        end else if (state.going_up) begin
          if (up_angle >= {1'b0, cfg.angle_hi}) begin
            state_next.scan_angle = cfg.angle_hi;
            state_next.going_up = 1'b0;
            dwell = 1'b1;
          end else begin
            state_next.scan_angle = up_angle[ANGLE_W-1:0];
          end
        end else begin
          if ($signed(down_angle) <= $signed({1'b0, cfg.angle_lo})) begin
            state_next.scan_angle = cfg.angle_lo;
            state_next.going_up = 1'b1;
            dwell = 1'b1;
          end else begin
            state_next.scan_angle = down_angle[ANGLE_W-1:0];
          end
        end
      end
    endcase

    result.servo_angle = state.scan_angle;
    result.mode = mode_code(state_next.scan_mode);
    result.fire = fire;
    result.target_angle = state_next.held_angle;
    result.end_dwell = dwell;
  end

endmodule

### hw/rtl/sweep_detect_verify_scanner_core.sv
`timescale 1ns / 1ps

// Sweep, detect and verify scanner.
// Each request on step_in is one scan step: an echo width in microseconds and a
// millisecond timestamp. For every step taken while not paused, one request
// leaves on result_out with the commanded servo angle, the new mode, the fire
// flag, the latched target angle and the end-of-sweep dwell flag. Steps taken
// while paused are consumed and give no result.
// A step is held in an input register while the scan logic runs on it, and its
// result is written to an output register once that register is free. While
// result_out is not stalled, one step is accepted every cycle; the limit is the
// single pass through the scan state update.
// When result_out is stalled, the output register holds its result and one more
// step can wait in the input register; step_in ready then drops until the
// receiver takes the result.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// by the user only while no step is in flight; this is not enforced. Reset
// clears both registers, restores config defaults and sweeps up from angle 0.

module sweep_detect_verify_scanner_core
  import sdv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sdv_step_if.sink             step_in,
  sdv_result_if.source         result_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t              cfg;
  scan_state_t       state;
  scan_state_t       state_next;
  result_t           result_next;
  result_t           result;
  logic              s1_valid;
  logic [ECHO_W-1:0] s1_echo;
  logic [TIME_W-1:0] s1_now;
  logic              out_valid;
  logic              out_free;
  logic              s1_fire;
  logic              s1_emit;

  sdv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdv_step u_step (
    .cfg        (cfg),
    .state      (state),
    .echo_us    (s1_echo),
    .now_ms     (s1_now),
    .state_next (state_next),
    .result     (result_next)
  );

  assign out_free = !out_valid || result_out.ready;
  assign s1_fire = s1_valid && (cfg.paused || out_free);
  assign s1_emit = s1_fire && !cfg.paused;
  assign step_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step_in.ready) begin
      s1_valid <= step_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_in.ready && step_in.valid) begin
      s1_echo <= step_in.echo_us;
      s1_now <= step_in.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.scan_mode <= MODE_SWEEP;
      state.going_up <= 1'b1;
      state.scan_angle <= RST_ANGLE_LO;
      state.mode_start_ms <= '0;
      state.held_angle <= RST_HELD_ANGLE;
    end else if (s1_emit) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      result <= result_next;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.servo_angle = result.servo_angle;
  assign result_out.mode = result.mode;
  assign result_out.fire = result.fire;
  assign result_out.target_angle = result.target_angle;
  assign result_out.end_dwell = result.end_dwell;

  a_fire_enters_cooldown: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.fire |-> result.mode == MODE_CODE_COOL)
    else $error("Fire reported without entering cooldown.");

  a_dwell_only_sweeping: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.end_dwell |-> result.mode == MODE_CODE_SWEEP)
    else $error("End dwell reported outside sweeping.");

  a_fire_at_held_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.fire |-> result.servo_angle == result.target_angle)
    else $error("Fire reported away from the latched target angle.");

  a_stalled_step_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_now) && $stable(s1_echo))
    else $error("Waiting step lost from the input register.");

endmodule

### bench/sweep_detect_verify_scanner_core_test.sv
`timescale 1ns / 1ps

module sweep_detect_verify_scanner_core_test;
  import sdv_pkg::*;

  localparam int DRAIN_CYCLES   = 6;
  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_STEPS    = 52;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_us;
    logic [TIME_W-1:0] now_ms;
  } scan_req_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SLOW} rx_pattern_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  sdv_step_if step_bus ();
  sdv_result_if result_bus ();

  sweep_detect_verify_scanner_core dut (
    .clk(clk),
    .rst(rst),
    .step_in(step_bus),
    .result_out(result_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration and scan state.
  cfg_t shadow_cfg;
  logic [MODE_W-1:0]  sc_mode;
  logic               sc_up;
  logic [ANGLE_W-1:0] sc_angle;
  logic [TIME_W-1:0]  sc_start;
  logic [ANGLE_W-1:0] sc_held;

  scan_req_t step_backlog[$];
  result_t   due_results[$];
  result_t   predicted;
  result_t   seen;
  result_t   oldest;

  logic [TIME_W-1:0] clock_ms;
  bit          step_taken;
  bit          long_hold_req;
  int          error_count;
  int          steps_seen;
  int          results_seen;
  int          fires_seen;
  int          reversals_seen;
  int          settings_used;
  int          burst_left;
  int          gap_left;
  int          hold_left;
  int          pattern_left;
  int          slow_phase;
  int          idle_cycles;
  rx_pattern_t rx_pattern;

  always #6 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic bit predict_scan(input logic [ECHO_W-1:0] echo,
                                      input logic [TIME_W-1:0] now,
                                      output result_t r);
    bit hit;
    int up_a;
    int dn_a;
    logic fire;
    logic dwell;
    logic [ANGLE_W-1:0] servo;
    r = '0;
    if (shadow_cfg.paused) return 0;
    servo = sc_angle;
    fire = 1'b0;
    dwell = 1'b0;
    hit = (echo > MIN_ECHO_US) &&
          (int'(echo) * 17 <= int'(shadow_cfg.threshold_cm) * 1000);
    case (sc_mode)
      MODE_CODE_VERIFY: begin
        if (hit) begin
          if (TIME_W'(now - sc_start) >= TIME_W'(shadow_cfg.verify_ms)) begin
            fire = 1'b1;
            sc_mode = MODE_CODE_COOL;
            sc_start = now;
          end
        end else begin
          sc_mode = MODE_CODE_SWEEP;
        end
      end
      MODE_CODE_COOL: begin
        if (hit) sc_start = now;
        if (TIME_W'(now - sc_start) >= TIME_W'(shadow_cfg.cooldown_ms))
          sc_mode = MODE_CODE_SWEEP;
      end
      default: begin
        sc_mode = MODE_CODE_SWEEP;
        if (hit) begin
          sc_mode = MODE_CODE_VERIFY;
          sc_start = now;
          sc_held = sc_angle;
        end else if (sc_up) begin
          up_a = int'(sc_angle) + int'(shadow_cfg.angle_stride);
          if (up_a >= int'(shadow_cfg.angle_hi)) begin
            up_a = int'(shadow_cfg.angle_hi);
            sc_up = 1'b0;
            dwell = 1'b1;
          end
          sc_angle = ANGLE_W'(up_a);
        end else begin
          dn_a = int'(sc_angle) - int'(shadow_cfg.angle_stride);
          if (dn_a <= int'(shadow_cfg.angle_lo)) begin
            dn_a = int'(shadow_cfg.angle_lo);
            sc_up = 1'b1;
            dwell = 1'b1;
          end
          sc_angle = ANGLE_W'(dn_a);
        end
      end
    endcase
    r.servo_angle = servo;
    r.mode = sc_mode;
    r.fire = fire;
    r.target_angle = sc_held;
    r.end_dwell = dwell;
    return 1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DAT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ANGLE_LO:     shadow_cfg.angle_lo = ANGLE_W'(value);
      CFG_ANGLE_HI:     shadow_cfg.angle_hi = ANGLE_W'(value);
      CFG_ANGLE_STRIDE: shadow_cfg.angle_stride = ANGLE_W'(value);
      CFG_THRESHOLD_CM: shadow_cfg.threshold_cm = THRESH_W'(value);
      CFG_VERIFY_MS:    shadow_cfg.verify_ms = MS_W'(value);
      CFG_COOLDOWN_MS:  shadow_cfg.cooldown_ms = MS_W'(value);
      CFG_PAUSED:       shadow_cfg.paused = value[0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input int unsigned lo, input int unsigned hi,
                                input int unsigned stride, input int unsigned thr,
                                input int unsigned ver, input int unsigned cool);
    write_reg(CFG_ANGLE_LO, lo);
    write_reg(CFG_ANGLE_HI, hi);
    write_reg(CFG_ANGLE_STRIDE, stride);
    write_reg(CFG_THRESHOLD_CM, thr);
    write_reg(CFG_VERIFY_MS, ver);
    write_reg(CFG_COOLDOWN_MS, cool);
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (step_backlog.size() != 0 || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_step(input int unsigned echo, input logic [TIME_W-1:0] now);
    scan_req_t req;
    req.echo_us = ECHO_W'(echo);
    req.now_ms = now;
    step_backlog.push_back(req);
    clock_ms = now;
  endtask

  function automatic int unsigned hit_limit();
    int unsigned lim;
    lim = int'(shadow_cfg.threshold_cm) * 1000 / 17;
    if (lim > 16383) lim = 16383;
    return lim;
  endfunction

  function automatic int unsigned miss_echo();
    int unsigned lim;
    lim = hit_limit();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(0, 100);
      default: begin
        if (lim < 16383) return $urandom_range(lim + 1, 16383);
        return $urandom_range(0, 100);
      end
    endcase
  endfunction

  function automatic int unsigned hit_echo();
    int unsigned lim;
    lim = hit_limit();
    if (lim <= 100) return miss_echo();
    return $urandom_range(101, lim);
  endfunction

  function automatic logic [TIME_W-1:0] next_time();
    int unsigned span;
    int unsigned pick;
    span = (shadow_cfg.verify_ms > shadow_cfg.cooldown_ms) ?
           shadow_cfg.verify_ms : shadow_cfg.cooldown_ms;
    pick = $urandom_range(0, 9);
    if (pick < 6) return clock_ms + $urandom_range(0, span / 3 + 20);
    if (pick < 9) return clock_ms + $urandom_range(span / 2, span + span / 4 + 10);
    return clock_ms + $urandom;
  endfunction

  task automatic queue_random_steps(input int count);
    int made;
    int len;
    int kind;
    int unsigned echo;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(2, 8);
      for (int i = 0; i < len; i++) begin
        if (kind <= 5) begin
          echo = (i == len - 1 && $urandom_range(0, 1)) ? miss_echo() : hit_echo();
          queue_step(echo, next_time());
        end else if (kind <= 7) begin
          queue_step(miss_echo(), next_time());
        end else begin
          queue_step($urandom_range(0, 16383), $urandom);
        end
      end
      made += len;
    end
  endtask

  task automatic random_settings(input int phase);
    int unsigned lo, hi, stride, thr, ver, cool;
    case ($urandom_range(0, 4))
      0: lo = 0;
      1: lo = 1800;
      2: lo = 2047;
      default: lo = $urandom_range(0, 1400);
    endcase
    case ($urandom_range(0, 4))
      0: hi = 1800;
      1: hi = 0;
      2: hi = 2047;
      default: hi = lo + $urandom_range(40, 400);
    endcase
    if (hi > 2047) hi = 1800;
    case ($urandom_range(0, 7))
      0: stride = 0;
      1: stride = 1800;
      2: stride = 2047;
      3: stride = 1;
      default: stride = $urandom_range(5, 120);
    endcase
    case ($urandom_range(0, 5))
      0: thr = 0;
      1: thr = 255;
      default: thr = $urandom_range(10, 255);
    endcase
    case ($urandom_range(0, 5))
      0: ver = 0;
      1: ver = 65535;
      default: ver = $urandom_range(1, 3000);
    endcase
    case ($urandom_range(0, 5))
      0: cool = 0;
      1: cool = 65535;
      default: cool = $urandom_range(1, 3000);
    endcase
    if (phase == 1) begin
      lo = 1500;
      hi = 200;
    end
    if (phase == 2) stride = 0;
    if (phase == 3) begin
      thr = 255;
      ver = 65535;
      cool = 65535;
    end
    write_settings(lo, hi, stride, thr, ver, cool);
  endtask

  // Driver: offers queued steps in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      step_bus.valid <= 1'b0;
    end else begin
      if (step_taken) begin
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (step_bus.valid && !step_taken) begin
      end else if (gap_left > 0) begin
        step_bus.valid <= 1'b0;
        gap_left--;
      end else if (step_backlog.size() > 0) begin
        step_bus.valid <= 1'b1;
        step_bus.echo_us <= step_backlog[0].echo_us;
        step_bus.now_ms <= step_backlog[0].now_ms;
      end else begin
        step_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: its own ready pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        if (pattern_left <= 0) begin
          rx_pattern = rx_pattern_t'($urandom_range(0, 2));
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        slow_phase++;
        case (rx_pattern)
          RX_OPEN:   result_bus.ready <= 1'b1;
          RX_RANDOM: result_bus.ready <= 1'($urandom_range(0, 1));
          default:   result_bus.ready <= (slow_phase % 4 == 0);
        endcase
      end
    end
  end

  // Monitor: predicts on each accepted step and checks each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      step_taken = step_bus.valid && step_bus.ready;
      if (step_taken) begin
        void'(step_backlog.pop_front());
        steps_seen++;
        if (predict_scan(step_bus.echo_us, step_bus.now_ms, predicted))
          due_results.push_back(predicted);
      end
      if (result_bus.valid && result_bus.ready) begin
        seen.servo_angle = result_bus.servo_angle;
        seen.mode = result_bus.mode;
        seen.fire = result_bus.fire;
        seen.target_angle = result_bus.target_angle;
        seen.end_dwell = result_bus.end_dwell;
        results_seen++;
        if (seen.fire) fires_seen++;
        if (seen.end_dwell) reversals_seen++;
        if (due_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with none outstanding", results_seen));
        end else begin
          oldest = due_results.pop_front();
          if (seen.servo_angle !== oldest.servo_angle)
            flag_error($sformatf("result %0d servo_angle %0d, expected %0d",
                                 results_seen, seen.servo_angle, oldest.servo_angle));
          if (seen.mode !== oldest.mode)
            flag_error($sformatf("result %0d mode %0d, expected %0d",
                                 results_seen, seen.mode, oldest.mode));
          if (seen.fire !== oldest.fire)
            flag_error($sformatf("result %0d fire %0d, expected %0d",
                                 results_seen, seen.fire, oldest.fire));
          if (seen.target_angle !== oldest.target_angle)
            flag_error($sformatf("result %0d target_angle %0d, expected %0d",
                                 results_seen, seen.target_angle, oldest.target_angle));
          if (seen.end_dwell !== oldest.end_dwell)
            flag_error($sformatf("result %0d end_dwell %0d, expected %0d",
                                 results_seen, seen.end_dwell, oldest.end_dwell));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (step_bus.valid && step_bus.ready) ||
        (result_bus.valid && result_bus.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    step_bus.valid = 1'b0;
    step_bus.echo_us = '0;
    step_bus.now_ms = '0;
    result_bus.ready = 1'b0;
    shadow_cfg.angle_lo = RST_ANGLE_LO;
    shadow_cfg.angle_hi = RST_ANGLE_HI;
    shadow_cfg.angle_stride = RST_ANGLE_STRIDE;
    shadow_cfg.threshold_cm = RST_THRESHOLD_CM;
    shadow_cfg.verify_ms = RST_VERIFY_MS;
    shadow_cfg.cooldown_ms = RST_COOLDOWN_MS;
    shadow_cfg.paused = 1'b0;
    sc_mode = MODE_CODE_SWEEP;
    sc_up = 1'b1;
    sc_angle = RST_ANGLE_LO;
    sc_start = '0;
    sc_held = RST_HELD_ANGLE;
    clock_ms = '0;
    step_taken = 1'b0;
    long_hold_req = 1'b0;
    error_count = 0;
    steps_seen = 0;
    results_seen = 0;
    fires_seen = 0;
    reversals_seen = 0;
    settings_used = 1;
    burst_left = $urandom_range(1, 30);
    gap_left = 0;
    hold_left = 0;
    pattern_left = 0;
    slow_phase = 0;
    idle_cycles = 0;
    rx_pattern = RX_OPEN;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Echo boundaries, a full verify and cooldown cycle, a miss while
    // verifying, and a verify window that spans the timestamp wrap.
    queue_step(0, 32'd0);
    queue_step(16383, 32'd1);
    queue_step(100, 32'd2);
    queue_step(2942, 32'd3);
    queue_step(101, 32'd10);
    queue_step(2941, 32'd1010);
    queue_step(500, 32'd2010);
    queue_step(500, 32'd3000);
    queue_step(0, 32'd5999);
    queue_step(0, 32'd6000);
    queue_step(200, 32'd6100);
    queue_step(0, 32'd6200);
    queue_step(150, 32'hFFFF_FF00);
    queue_step(150, 32'hFFFF_FFFF);
    queue_step(150, 32'h0000_06D0);
    wait_idle();

    // Narrow sweep that reverses at both limits, then zero verify and
    // cooldown times.
    write_settings(100, 140, 20, 255, 0, 0);
    queue_step(15001, clock_ms + 1);
    queue_step(16383, clock_ms + 1);
    queue_step(0, clock_ms + 1);
    queue_step(15001, clock_ms + 1);
    queue_step(0, clock_ms + 1);
    queue_step(15000, clock_ms + 1);
    queue_step(15000, clock_ms);
    queue_step(0, clock_ms + 1);
    queue_step(0, clock_ms + 1);
    wait_idle();

    // Steps while paused are consumed and change nothing.
    write_reg(CFG_PAUSED, 1);
    for (int i = 0; i < 20; i++) queue_step($urandom_range(0, 16383), $urandom);
    wait_idle();
    write_reg(CFG_PAUSED, 0);
    write_reg(CFG_UNUSED, 16'hFFFF);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings(p);
      if (p == 4) begin
        @(posedge clk);
        long_hold_req = 1'b1;
      end
      queue_random_steps(PHASE_STEPS);
      wait_idle();
    end

    while (due_results.size() != 0) begin
      oldest = due_results.pop_front();
      flag_error($sformatf("expected result never arrived, servo_angle %0d",
                           oldest.servo_angle));
    end

    $display("covered %0d steps, %0d results, %0d fires, %0d sweep reversals",
             steps_seen, results_seen, fires_seen, reversals_seen);
    $display("across %0d register settings plus a paused stretch and a long output stall",
             settings_used);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
